// ===== rtl/dbol_pkg.sv =====
`default_nettype none
package dbol_pkg;

    // list geometry
    localparam int CAPACITY  = 64;
    localparam int NUM_LISTS = 2;

    // field widths of the streaming items
    localparam int OP_W  = 3;
    localparam int LSEL_W = 1;
    localparam int ID_W  = 16;
    localparam int POS_W = 6;
    localparam int CNT_W = 7;

    // bus widths
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 1;

    // derived storage widths
    localparam int FILL_W = $clog2(CAPACITY + 1);
    localparam int ROW_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int PTR_W  = (FILL_W > POS_W) ? FILL_W : POS_W;
    localparam int ADDR_W = $clog2(NUM_LISTS * CAPACITY);
    localparam int FIDX_W = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
    localparam int DEPTH  = NUM_LISTS * CAPACITY;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_ZONE_ENABLE = 0;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH         = 3'd0,
        OP_COUNT        = 3'd1,
        OP_READ         = 3'd2,
        OP_REMOVE_AT    = 3'd3,
        OP_REMOVE_MATCH = 3'd4,
        OP_CLEAR        = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_READ_WAIT,
        ST_SCAN,
        ST_SHIFT,
        ST_FINISH
    } state_t;

    // where the entry pointer is loaded from
    typedef enum logic [2:0] {
        PTR_ZERO,
        PTR_ONE,
        PTR_POS,
        PTR_POS1,
        PTR_HIT1
    } ptr_src_t;

    typedef struct packed {
        logic     capture;
        logic     clr_fill;
        logic     inc_fill;
        logic     dec_fill;
        logic     ld_ptr;
        ptr_src_t ptr_src;
        logic     rd_en;
        logic     shift_wr;
        logic     push_wr;
        logic     set_ok;
        logic     ld_rd;
        logic     load_out;
    } dp_cmd_t;

    typedef struct packed {
        op_t  op;
        logic en_ok;
        logic id_zero;
        logic full;
        logic pos_in;
        logic ptr_end;
        logic rd_pend;
        logic hit;
        logic out_free;
    } dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/dbol_ram.sv =====
`default_nettype none
module dbol_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== rtl/dbol_ctrl.sv =====
`default_nettype none
module dbol_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire dbol_pkg::dp_stat_t stat,
    output dbol_pkg::dp_cmd_t       cmd
);
    import dbol_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                state_next = ST_FINISH;
                if (stat.op != OP_CLEAR && stat.en_ok) begin
                    case (stat.op)
                        OP_PUSH: begin
                            if (!stat.id_zero && stat.full) begin
                                state_next = ST_SHIFT;
                            end
                        end
                        OP_READ: begin
                            if (stat.pos_in) begin
                                state_next = ST_READ_WAIT;
                            end
                        end
                        OP_REMOVE_AT: begin
                            if (stat.pos_in) begin
                                state_next = ST_SHIFT;
                            end
                        end
                        OP_REMOVE_MATCH: begin
                            if (!stat.id_zero) begin
                                state_next = ST_SCAN;
                            end
                        end
                        default: state_next = ST_FINISH;
                    endcase
                end
            end
            ST_READ_WAIT: state_next = ST_FINISH;
            ST_SCAN: begin
                if (stat.rd_pend && stat.hit) begin
                    state_next = ST_SHIFT;
                end else if (stat.ptr_end) begin
                    state_next = ST_FINISH;
                end
            end
            ST_SHIFT: begin
                if (stat.ptr_end && !stat.rd_pend) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_DECODE: begin
                if (stat.op == OP_CLEAR) begin
                    cmd.clr_fill = 1'b1;
                    cmd.set_ok   = 1'b1;
                end else if (stat.en_ok) begin
                    case (stat.op)
                        OP_PUSH: begin
                            if (!stat.id_zero) begin
                                if (stat.full) begin
                                    cmd.ld_ptr  = 1'b1;
                                    cmd.ptr_src = PTR_ONE;
                                end else begin
                                    cmd.push_wr  = 1'b1;
                                    cmd.inc_fill = 1'b1;
                                    cmd.set_ok   = 1'b1;
                                end
                            end
                        end
                        OP_COUNT: cmd.set_ok = 1'b1;
                        OP_READ: begin
                            if (stat.pos_in) begin
                                cmd.ld_ptr  = 1'b1;
                                cmd.ptr_src = PTR_POS;
                                cmd.rd_en   = 1'b1;
                            end
                        end
                        OP_REMOVE_AT: begin
                            if (stat.pos_in) begin
                                cmd.ld_ptr  = 1'b1;
                                cmd.ptr_src = PTR_POS1;
                            end
                        end
                        OP_REMOVE_MATCH: begin
                            if (!stat.id_zero) begin
                                cmd.ld_ptr  = 1'b1;
                                cmd.ptr_src = PTR_ZERO;
                            end
                        end
                        default: cmd.set_ok = 1'b0;
                    endcase
                end
            end
            ST_READ_WAIT: begin
                cmd.ld_rd  = 1'b1;
                cmd.set_ok = 1'b1;
            end
            ST_SCAN: begin
                // compare the entry read last cycle, else fetch the next one
                if (stat.rd_pend && stat.hit) begin
                    cmd.ld_ptr  = 1'b1;
                    cmd.ptr_src = PTR_HIT1;
                end else if (!stat.ptr_end) begin
                    cmd.rd_en = 1'b1;
                end
            end
            ST_SHIFT: begin
                // move the entry read last cycle one place down
                cmd.shift_wr = stat.rd_pend;
                if (!stat.ptr_end) begin
                    cmd.rd_en = 1'b1;
                end else if (!stat.rd_pend) begin
                    cmd.set_ok = 1'b1;
                    if (stat.op == OP_PUSH) begin
                        cmd.push_wr = 1'b1;
                    end else begin
                        cmd.dec_fill = 1'b1;
                    end
                end
            end
            ST_FINISH: cmd.load_out = stat.out_free;
            default: cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/dbol_dpath.sv =====
`default_nettype none
module dbol_dpath (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic [dbol_pkg::OP_W-1:0]   in_opcode,
    input  wire logic [dbol_pkg::LSEL_W-1:0] in_list_select,
    input  wire logic [dbol_pkg::ID_W-1:0]   in_item_id,
    input  wire logic [dbol_pkg::POS_W-1:0]  in_position,
    input  wire logic                        zone_enable,
    input  wire dbol_pkg::dp_cmd_t           cmd,
    output dbol_pkg::dp_stat_t               stat,
    input  wire logic                        m_tready,
    output logic                             m_tvalid,
    output logic                             m_success,
    output logic      [dbol_pkg::CNT_W-1:0]  m_entry_count,
    output logic      [dbol_pkg::ID_W-1:0]   m_read_id
);
    import dbol_pkg::*;

    // captured command
    op_t                op_reg;
    logic [LSEL_W-1:0]  lst_reg;
    logic [ID_W-1:0]    id_reg;
    logic [POS_W-1:0]   pos_reg;

    logic [FILL_W-1:0]  fill_reg [NUM_LISTS];
    logic [PTR_W-1:0]   ptr_reg;
    logic [PTR_W-1:0]   prev_reg;
    logic               rd_pend_reg;
    logic               ok_reg;
    logic [ID_W-1:0]    rd_reg;

    logic               m_valid_reg;
    logic               m_success_reg;
    logic [CNT_W-1:0]   m_count_reg;
    logic [ID_W-1:0]    m_read_id_reg;

    logic               lst_ok;
    logic [FIDX_W-1:0]  lst_idx;
    logic [FILL_W-1:0]  fill_cur;
    logic [PTR_W-1:0]   fill_ext;
    logic [PTR_W-1:0]   pos_ext;
    logic               full;
    logic [PTR_W-1:0]   ptr_val;
    logic [PTR_W-1:0]   prev_m1;
    logic [ROW_W-1:0]   push_row;
    logic [ADDR_W-1:0]  base;
    logic [ADDR_W-1:0]  raddr;
    logic [ADDR_W-1:0]  waddr;
    logic [ID_W-1:0]    wdata;
    logic               we;
    logic [ID_W-1:0]    ram_rdata;

    // selected list
    assign lst_ok   = (int'(lst_reg) < NUM_LISTS);
    assign lst_idx  = FIDX_W'(lst_reg);
    assign fill_cur = lst_ok ? fill_reg[lst_idx] : '0;
    assign fill_ext = PTR_W'(fill_cur);
    assign pos_ext  = PTR_W'(pos_reg);
    assign full     = (fill_cur == FILL_W'(CAPACITY));
    assign base     = (lst_reg != '0) ? ADDR_W'(CAPACITY) : '0;

    // entry pointer, loaded or running
    always_comb begin
        ptr_val = ptr_reg;
        if (cmd.ld_ptr) begin
            case (cmd.ptr_src)
                PTR_ZERO: ptr_val = '0;
                PTR_ONE:  ptr_val = PTR_W'(1);
                PTR_POS:  ptr_val = pos_ext;
                PTR_POS1: ptr_val = pos_ext + PTR_W'(1);
                PTR_HIT1: ptr_val = prev_reg + PTR_W'(1);
                default:  ptr_val = ptr_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            ptr_reg  <= ptr_val + PTR_W'(1);
            prev_reg <= ptr_val;
        end else if (cmd.ld_ptr) begin
            ptr_reg  <= ptr_val;
        end
    end

    // memory addressing
    assign prev_m1  = prev_reg - PTR_W'(1);
    assign push_row = full ? ROW_W'(CAPACITY - 1) : fill_cur[ROW_W-1:0];
    assign raddr    = base + ADDR_W'(ptr_val[ROW_W-1:0]);
    assign we       = cmd.shift_wr | cmd.push_wr;
    assign waddr    = base + (cmd.push_wr ? ADDR_W'(push_row) : ADDR_W'(prev_m1[ROW_W-1:0]));
    assign wdata    = cmd.push_wr ? id_reg : ram_rdata;

    dbol_ram #(
        .WIDTH(ID_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .clk  (aclk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .re   (cmd.rd_en),
        .raddr(raddr),
        .rdata(ram_rdata)
    );

    // command capture
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg  <= op_t'(in_opcode);
            lst_reg <= in_list_select;
            id_reg  <= in_item_id;
            pos_reg <= in_position;
        end
    end

    // fill counts
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_LISTS; i++) begin
                fill_reg[i] <= '0;
            end
        end else begin
            for (int i = 0; i < NUM_LISTS; i++) begin
                if (cmd.clr_fill) begin
                    fill_reg[i] <= '0;
                end else if (lst_ok && FIDX_W'(i) == lst_idx) begin
                    if (cmd.inc_fill) begin
                        fill_reg[i] <= fill_reg[i] + FILL_W'(1);
                    end else if (cmd.dec_fill) begin
                        fill_reg[i] <= fill_reg[i] - FILL_W'(1);
                    end
                end
            end
        end
    end

    // read tracking and result flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_pend_reg <= 1'b0;
            ok_reg      <= 1'b0;
        end else begin
            rd_pend_reg <= cmd.rd_en;
            if (cmd.capture) begin
                ok_reg <= 1'b0;
            end else if (cmd.set_ok) begin
                ok_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            rd_reg <= '0;
        end else if (cmd.ld_rd) begin
            rd_reg <= ram_rdata;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_success_reg <= ok_reg;
            m_count_reg   <= (zone_enable && lst_ok) ? CNT_W'(fill_cur) : '0;
            m_read_id_reg <= rd_reg;
        end
    end

    assign m_tvalid      = m_valid_reg;
    assign m_success     = m_success_reg;
    assign m_entry_count = m_count_reg;
    assign m_read_id     = m_read_id_reg;

    // status to the controller
    always_comb begin
        stat          = '0;
        stat.op       = op_reg;
        stat.en_ok    = zone_enable && lst_ok;
        stat.id_zero  = (id_reg == '0);
        stat.full     = full;
        stat.pos_in   = (pos_ext < fill_ext);
        stat.ptr_end  = (ptr_reg >= fill_ext);
        stat.rd_pend  = rd_pend_reg;
        stat.hit      = (ram_rdata == id_reg);
        stat.out_free = !m_valid_reg || m_tready;
    end

endmodule
`default_nettype wire

// ===== rtl/dual_bounded_ordered_list_top.sv =====
`default_nettype none
// Two ordered lists of 16-bit identifiers in one shared RAM with one write port
// and a registered read port, CAPACITY entries each, oldest at index 0. One
// command is handled at a time and each gives exactly one result transfer.
// Count, clear, rejected commands and a push into a list that is not full go
// from decode straight to the result; a read waits for the registered RAM
// data. Remove-at shifts the entries behind the position down. A push into a
// full list shifts all entries down, dropping the oldest. Remove-first-match
// scans from index 0 and shifts the entries behind the first match; the empty
// marker is rejected at decode. Shifts move one entry per cycle through the
// RAM: each shifted entry is read in one cycle and written one place down in
// the next. The next input transfer can come at the same edge as the earliest
// result transfer. A new command is taken while the previous result still
// waits on m_tready; the one after it stalls until that result leaves. No
// clearing pass runs after reset: the fill counts alone mark entries valid.
module dual_bounded_ordered_list_top (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // input channel
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [dbol_pkg::S_TDATA_W-1:0]   s_tdata,  // item_id, position, zero pad
    input  wire logic [dbol_pkg::S_TUSER_W-1:0]   s_tuser,  // opcode, list_select
    // result channel
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [dbol_pkg::M_TDATA_W-1:0]   m_tdata,  // entry_count, read_id, zero pad
    output logic      [dbol_pkg::M_TUSER_W-1:0]   m_tuser,  // success
    // configuration port
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [dbol_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [dbol_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [dbol_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                  pready
);
    import dbol_pkg::*;

    dp_cmd_t           cmd;
    dp_stat_t          stat;
    logic              zone_enable_reg;
    logic              reg_hit;
    logic              m_success;
    logic [CNT_W-1:0]  m_count;
    logic [ID_W-1:0]   m_read_id;

    // register decode, word aligned
    assign reg_hit = (paddr[APB_ADDR_W-1:2] == (APB_ADDR_W - 2)'(REG_ZONE_ENABLE));
    assign pready  = 1'b1;
    assign prdata  = reg_hit ? APB_DATA_W'(zone_enable_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zone_enable_reg <= 1'b1;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            zone_enable_reg <= pwdata[0];
        end
    end

    dbol_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    dbol_dpath u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_opcode     (s_tuser[OP_W-1:0]),
        .in_list_select(s_tuser[OP_W+LSEL_W-1:OP_W]),
        .in_item_id    (s_tdata[ID_W-1:0]),
        .in_position   (s_tdata[ID_W+POS_W-1:ID_W]),
        .zone_enable   (zone_enable_reg),
        .cmd           (cmd),
        .stat          (stat),
        .m_tready      (m_tready),
        .m_tvalid      (m_tvalid),
        .m_success     (m_success),
        .m_entry_count (m_count),
        .m_read_id     (m_read_id)
    );

    // result packing
    assign m_tuser = m_success;
    assign m_tdata = M_TDATA_W'({m_read_id, m_count});

`ifndef SYNTH
    // one command in flight: no back-to-back input transfers
    a_single_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input transfer taken while a command is in progress");

    // reported count never exceeds the list capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (int'(m_count) <= CAPACITY))
        else $error("entry count above capacity");

    // a nonzero identifier only comes back from a successful read
    a_read_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_read_id != '0)) |-> m_success)
        else $error("read data returned without success");

    // the count and read identifier do not change while the result waits on the sink
    a_count_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(m_count) && $stable(m_read_id))
        else $error("result changed while stalled");
`endif

endmodule
`default_nettype wire
